// ===== src/k2r_pkg.sv =====
package k2r_pkg;

    typedef struct packed {
        logic [23:0] cur_char;
        logic [2:0]  cur_len;
        logic [23:0] next_char;
        logic [2:0]  next_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] out_count;
        logic       pass_through;
        logic [2:0] used_bytes;
        logic [1:0] used_chars;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [6:0] k;
        logic [6:0] nk;
        logic [2:0] len;
        logic [2:0] nlen;
    } t_cls_item;

    localparam logic [7:0] UTF8_LEAD = 8'he3;
    localparam logic [6:0] K_CHI     = 7'h21;
    localparam logic [6:0] K_SMALL_TSU = 7'h23;
    localparam logic [6:0] K_N       = 7'h53;
    localparam logic [6:0] K_SMALL_YA = 7'h43;
    localparam logic [6:0] K_SMALL_YU = 7'h45;
    localparam logic [6:0] K_SMALL_YO = 7'h47;
    localparam logic [6:0] K_LAST    = 7'h5a;

    // romaji text per kana index, bytes packed first byte high, zero padded
    function automatic logic [31:0] kana_text(input logic [6:0] k);
        logic [31:0] t;
        t = 32'h0;
        case (k)
            7'h01: t = "xa";  7'h02: t = "a";   7'h03: t = "xi";  7'h04: t = "i";
            7'h05: t = "xu";  7'h06: t = "u";   7'h07: t = "xe";  7'h08: t = "e";
            7'h09: t = "xo";  7'h0a: t = "o";
            7'h0b: t = "ka";  7'h0c: t = "ga";  7'h0d: t = "ki";  7'h0e: t = "gi";
            7'h0f: t = "ku";  7'h10: t = "gu";  7'h11: t = "ke";  7'h12: t = "ge";
            7'h13: t = "ko";  7'h14: t = "go";
            7'h15: t = "sa";  7'h16: t = "za";  7'h17: t = "shi"; 7'h18: t = "ji";
            7'h19: t = "su";  7'h1a: t = "zu";  7'h1b: t = "se";  7'h1c: t = "ze";
            7'h1d: t = "so";  7'h1e: t = "zo";
            7'h1f: t = "ta";  7'h20: t = "da";  7'h21: t = "chi"; 7'h22: t = "ji";
            7'h23: t = "xtsu"; 7'h24: t = "tsu"; 7'h25: t = "zu"; 7'h26: t = "te";
            7'h27: t = "de";  7'h28: t = "to";  7'h29: t = "do";
            7'h2a: t = "na";  7'h2b: t = "ni";  7'h2c: t = "nu";  7'h2d: t = "ne";
            7'h2e: t = "no";
            7'h2f: t = "ha";  7'h30: t = "ba";  7'h31: t = "pa";  7'h32: t = "hi";
            7'h33: t = "bi";  7'h34: t = "pi";  7'h35: t = "hu";  7'h36: t = "bu";
            7'h37: t = "pu";  7'h38: t = "he";  7'h39: t = "be";  7'h3a: t = "pe";
            7'h3b: t = "ho";  7'h3c: t = "bo";  7'h3d: t = "po";
            7'h3e: t = "ma";  7'h3f: t = "mi";  7'h40: t = "mu";  7'h41: t = "me";
            7'h42: t = "mo";
            7'h43: t = "xya"; 7'h44: t = "ya";  7'h45: t = "xyu"; 7'h46: t = "yu";
            7'h47: t = "xyo"; 7'h48: t = "yo";
            7'h49: t = "ra";  7'h4a: t = "ri";  7'h4b: t = "ru";  7'h4c: t = "re";
            7'h4d: t = "ro";
            7'h4e: t = "xwa"; 7'h4f: t = "wa";  7'h50: t = "wi";  7'h51: t = "we";
            7'h52: t = "wo";
            7'h53: t = "n";   7'h54: t = "vu";  7'h55: t = "xka"; 7'h56: t = "xke";
            7'h57: t = "va";  7'h58: t = "vi";  7'h59: t = "ve";  7'h5a: t = "vo";
            default: t = 32'h0;
        endcase
        // left align: string literals come right aligned
        if (t[31:24] == 8'h0) t = t << 8;
        if (t[31:24] == 8'h0) t = t << 8;
        if (t[31:24] == 8'h0) t = t << 8;
        return t;
    endfunction

    function automatic logic [6:0] kana_index(input logic [23:0] c);
        logic [7:0] cp;
        logic [6:0] k;
        cp = {c[9:8], c[5:0]};
        k = 7'd0;
        if (c[23:16] == UTF8_LEAD && c[15:8] >= 8'h81 && c[15:8] <= 8'h83 &&
            c[7:0] >= 8'h80 && c[7:0] <= 8'hbf) begin
            if (cp >= 8'h41 && cp <= 8'h96) k = 7'(cp - 8'h40);
            else if (cp >= 8'ha1 && cp <= 8'hfa) k = 7'(cp - 8'ha0);
        end
        return k;
    endfunction

endpackage

// ===== src/k2r_front.sv =====
module k2r_front import k2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cls_item o_cls
);
    logic      r_valid;
    t_cls_item r_cls;
    t_cls_item n_cls;
    logic [2:0] w_len;

    always_comb begin
        w_len = i_item.cur_len;
        if (w_len == 3'd0) w_len = 3'd1;
        if (w_len > 3'd4) w_len = 3'd4;
        n_cls.len  = w_len;
        n_cls.nlen = i_item.next_len;
        n_cls.k    = (w_len == 3'd3) ? kana_index(i_item.cur_char) : 7'd0;
        n_cls.nk   = (w_len == 3'd3 && i_item.next_len == 3'd3)
                     ? kana_index(i_item.next_char) : 7'd0;
    end

    assign o_full  = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full) begin
            r_valid <= i_push;
        end
        if (i_push && !o_full) r_cls <= n_cls;
    end
endmodule

// ===== src/k2r_queue.sv =====
module k2r_queue import k2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cls_item i_cls,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cls_item o_cls
);
    // two entry queue so front and back stall on their own
    t_cls_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls   = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
        if (w_wr) r_mem[r_wp] <= i_cls;
    end
endmodule

// ===== src/k2r_back.sv =====
module k2r_back import k2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cls_item i_cls,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);
    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        logic [31:0] t, nt;
        logic [7:0]  ncons, sy, c0;
        logic [15:0] pre;
        logic [1:0]  plen;
        logic [31:0] buf_w;
        logic [2:0]  n;
        t = kana_text(i_cls.k);
        nt = kana_text(i_cls.nk);
        ncons = 8'h0;
        c0 = nt[31:24];
        if (i_cls.nk != 7'd0 && i_cls.nk <= K_LAST) begin
            if (i_cls.nk == K_CHI) ncons = "t";
            else begin
                ncons = (c0 == "a" || c0 == "i" || c0 == "u" || c0 == "e" || c0 == "o")
                        ? 8'h0 : c0;
            end
        end
        sy = 8'h0;
        if (i_cls.nk == K_SMALL_YA) sy = "a";
        else if (i_cls.nk == K_SMALL_YU) sy = "u";
        else if (i_cls.nk == K_SMALL_YO) sy = "o";
        plen = 2'd0;
        pre = 16'h0;
        case (i_cls.k)
            7'h0d: begin pre = "ky"; plen = 2'd2; end
            7'h0e: begin pre = "gy"; plen = 2'd2; end
            7'h17: begin pre = "sh"; plen = 2'd2; end
            7'h18: begin pre = {"j", 8'h0}; plen = 2'd1; end
            7'h21: begin pre = "ch"; plen = 2'd2; end
            7'h22: begin pre = {"j", 8'h0}; plen = 2'd1; end
            7'h2b: begin pre = "ny"; plen = 2'd2; end
            7'h32: begin pre = "hy"; plen = 2'd2; end
            7'h33: begin pre = "by"; plen = 2'd2; end
            7'h34: begin pre = "py"; plen = 2'd2; end
            7'h3f: begin pre = "my"; plen = 2'd2; end
            7'h4a: begin pre = "ry"; plen = 2'd2; end
            default: begin pre = 16'h0; plen = 2'd0; end
        endcase
        buf_w = 32'h0;
        n = 3'd0;
        n_item.used_bytes = i_cls.len;
        n_item.used_chars = 2'd1;
        if (i_cls.k != 7'd0) begin
            if (sy != 8'h0 && plen != 2'd0) begin
                if (plen == 2'd2) buf_w = {pre, sy, 8'h0};
                else buf_w = {pre[15:8], sy, 16'h0};
                n = 3'(plen) + 3'd1;
                n_item.used_bytes = 3'(i_cls.len + i_cls.nlen);
                n_item.used_chars = 2'd2;
            end else if (i_cls.k == K_SMALL_TSU && ncons != 8'h0) begin
                buf_w = {ncons, 24'h0};
                n = 3'd1;
            end else if (i_cls.k == K_N) begin
                buf_w[31:24] = (ncons == "b" || ncons == "p" || ncons == "m") ? "m" : "n";
                n = 3'd1;
                if ((i_cls.nk != 7'd0 && ncons == 8'h0) || ncons == "y") begin
                    buf_w[23:16] = "-";
                    n = 3'd2;
                end
            end else begin
                buf_w = t;
                n = (t[7:0] != 8'h0) ? 3'd4 : (t[15:8] != 8'h0) ? 3'd3 :
                    (t[23:16] != 8'h0) ? 3'd2 : (t[31:24] != 8'h0) ? 3'd1 : 3'd0;
            end
        end
        n_item.out_byte0    = buf_w[31:24];
        n_item.out_byte1    = buf_w[23:16];
        n_item.out_byte2    = buf_w[15:8];
        n_item.out_byte3    = buf_w[7:0];
        n_item.out_count    = n;
        n_item.pass_through = (n == 3'd0);
    end

    assign o_ready = !r_valid || i_pop;
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) r_item <= n_item;
    end
endmodule

// ===== src/kana_to_romaji_converter_top.sv =====
// Kana to romaji converter. Each item is one UTF-8 character with one character of
// lookahead; each gives exactly one result. One item per cycle sustained unless pop
// lags and full rises; results pass a classify register, a two entry queue and the
// romaji output register. Pass-through characters have out_count 0
// and the caller keeps the original bytes; used_bytes/used_chars tell how far to advance.
module kana_to_romaji_converter_top import k2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    logic      w_fv, w_fr, w_qv, w_qr;
    t_cls_item w_fc, w_qc;

    k2r_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .o_valid(w_fv), .i_ready(w_fr), .o_cls(w_fc)
    );
    k2r_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_cls(w_fc),
        .o_valid(w_qv), .i_ready(w_qr), .o_cls(w_qc)
    );
    k2r_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_cls(w_qc),
        .o_empty(empty), .i_pop(pop), .o_item
    );
endmodule

// ===== src/k2r_checker.sv =====
module k2r_checker import k2r_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item))) else $error("result dropped");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_item.pass_through == (o_item.out_count == 3'd0)))
        else $error("pass flag mismatch");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_item.out_count <= 3'd4 && o_item.used_chars != 2'd0))
        else $error("bad count");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("reset state");
endmodule

bind kana_to_romaji_converter_top k2r_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_item
);
